>>> hdl/indexed_block_allocator_unit_assert.svh
// Assertion macros used by the checker file of the allocator.
`ifndef INDEXED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define INDEXED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define IBA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed: same-cycle rule");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define IBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed: next-cycle rule");

`endif

>>> hdl/iba_pkg.sv
`timescale 1ns / 1ps

package iba_pkg;

    // Field widths of the item ports.
    localparam int BLK_IDX_W    = 6;
    localparam int LEN_W        = 6;
    localparam int STATUS_W     = 3;
    localparam int BLK_NUM_W    = 5;

    // Default map size and the largest data request that can be served.
    localparam int NUM_BLOCKS_DEF = 32;
    localparam int MAX_DATA       = 32;

    // Operation codes.
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_MARKED    = 3'd0,
        ST_INDEX     = 3'd1,
        ST_DATA      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NO_SPACE  = 3'd4
    } status_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                 clr;        // clear the free bit of the selected cell
        logic [BLK_IDX_W-1:0] sel;        // selected block number
        logic                 flush;      // drop any token in the chain
        logic                 shift_en;   // tokens advance one cell
        logic                 count_mode; // 1: counting pass, 0: allocation pass
    } iba_cmd_t;

    // Token handed from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] val;   // running free count, or blocks still needed
    } iba_tok_t;

endpackage

>>> hdl/indexed_block_allocator_unit.sv
// Mark items and allocate items with a bad index: one result, registered in the cycle after acceptance.
// Allocate item: the count token crosses the whole cell chain to the index or
// no-space result; the allocation token then gives one data result per free cell it passes,
// and the chain stalls with the output. Throughput: one single-result item a cycle while the
// output does not stall; after an allocation the next item can be accepted in the cycle its last
// result is taken. Reset (rst_n, asynchronous, active low) frees all blocks.
`timescale 1ns / 1ps

module indexed_block_allocator_unit #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [iba_pkg::BLK_IDX_W-1:0]  block_index,
    input  logic [iba_pkg::LEN_W-1:0]      file_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [iba_pkg::STATUS_W-1:0]   status,
    output logic [iba_pkg::BLK_NUM_W-1:0]  block_number,
    output logic                           last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_ALLOC
    } state_t;

    state_t                         state_reg, state_next;
    logic [iba_pkg::BLK_IDX_W-1:0]  idx_reg, idx_next;
    logic [iba_pkg::LEN_W-1:0]      len_reg, len_next;
    logic                           out_valid_reg, out_valid_next;
    iba_pkg::status_t               status_reg, status_next;
    logic [iba_pkg::BLK_NUM_W-1:0]  blk_num_reg, blk_num_next;
    logic                           last_reg, last_next;

    iba_pkg::iba_cmd_t              cmd;
    iba_pkg::iba_tok_t              inject_tok;
    iba_pkg::iba_tok_t              tok_chain [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]          hit_vec;
    logic [NUM_BLOCKS-1:0]          take_vec;
    logic [NUM_BLOCKS-1:0]          take_last_vec;

    logic                           shift_en;
    logic                           in_fire;
    logic                           in_range;
    logic                           hit_any;
    logic                           take_any;
    logic                           take_last;
    logic [iba_pkg::BLK_NUM_W-1:0]  take_blk;
    logic [iba_pkg::LEN_W-1:0]      total_free;

    // The chain moves only when the output register can take a new result.
    assign shift_en = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && shift_en;
    assign in_fire  = in_valid && in_ready;
    assign in_range = (block_index < iba_pkg::BLK_IDX_W'(NUM_BLOCKS));

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_number = blk_num_reg;
    assign last         = last_reg;

    // Row of cells, one per block, with the token passed from cell to cell.
    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_cell
        iba_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .tok_in    ((g == 0) ? inject_tok : tok_chain[(g == 0) ? 0 : g-1]),
            .tok_out   (tok_chain[g]),
            .hit       (hit_vec[g]),
            .take      (take_vec[g]),
            .take_last (take_last_vec[g])
        );
    end

    // Gather the block taken this cycle; at most one cell holds the token.
    always_comb
    begin
        take_blk = '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (take_vec[i])
            begin
                take_blk = take_blk | iba_pkg::BLK_NUM_W'(i);
            end
        end
    end

    assign hit_any    = |hit_vec;
    assign take_any   = |take_vec;
    assign take_last  = |(take_vec & take_last_vec);
    assign total_free = tok_chain[NUM_BLOCKS-1].val;

    // Controller: next state, cell commands and the next result.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        blk_num_next   = blk_num_reg;
        last_next      = last_reg;

        cmd.clr        = 1'b0;
        cmd.sel        = (state_reg == S_IDLE) ? block_index : idx_reg;
        cmd.flush      = 1'b0;
        cmd.shift_en   = shift_en;
        cmd.count_mode = (state_reg == S_COUNT);

        inject_tok     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    blk_num_next   = '0;
                    last_next      = 1'b1;
                    if (op == iba_pkg::OP_MARK)
                    begin
                        cmd.clr     = in_range;
                        status_next = in_range ? iba_pkg::ST_MARKED : iba_pkg::ST_BAD_INDEX;
                    end
                    else if (!hit_any)
                    begin
                        // Index block out of range or already used.
                        status_next = iba_pkg::ST_BAD_INDEX;
                    end
                    else
                    begin
                        // Start the counting pass; no result until it ends.
                        out_valid_next   = 1'b0;
                        idx_next         = block_index;
                        len_next         = file_length;
                        inject_tok.valid = 1'b1;
                        state_next       = S_COUNT;
                    end
                end
            end

            S_COUNT:
            begin
                if (shift_en && tok_chain[NUM_BLOCKS-1].valid)
                begin
                    out_valid_next = 1'b1;
                    if ((len_reg > iba_pkg::LEN_W'(iba_pkg::MAX_DATA)) || (total_free < len_reg))
                    begin
                        // Request too long or not enough free blocks; the index block stays free.
                        status_next  = iba_pkg::ST_NO_SPACE;
                        blk_num_next = '0;
                        last_next    = 1'b1;
                        cmd.flush    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        // Take the index block, then start the allocation pass.
                        cmd.clr      = 1'b1;
                        status_next  = iba_pkg::ST_INDEX;
                        blk_num_next = idx_reg[iba_pkg::BLK_NUM_W-1:0];
                        last_next    = (len_reg == '0);
                        if (len_reg == '0)
                        begin
                            cmd.flush  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            inject_tok.valid = 1'b1;
                            inject_tok.val   = len_reg;
                            state_next       = S_ALLOC;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                if (shift_en && take_any)
                begin
                    out_valid_next = 1'b1;
                    status_next    = iba_pkg::ST_DATA;
                    blk_num_next   = take_blk;
                    last_next      = take_last;
                    if (take_last)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        status_reg  <= status_next;
        blk_num_reg <= blk_num_next;
        last_reg    <= last_next;
    end

endmodule

>>> hdl/iba_cell.sv
`timescale 1ns / 1ps

module iba_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  iba_pkg::iba_cmd_t cmd,
    input  iba_pkg::iba_tok_t tok_in,
    output iba_pkg::iba_tok_t tok_out,
    output logic              hit,
    output logic              take,
    output logic              take_last
);

    logic              free_reg;
    logic              free_next;
    iba_pkg::iba_tok_t tok_reg;
    iba_pkg::iba_tok_t tok_next;
    logic              self_sel;

    assign self_sel = (cmd.sel == iba_pkg::BLK_IDX_W'(CELL_IDX));

    // The selected block is free.
    assign hit = free_reg && self_sel;

    // During the allocation pass the token takes this block if it still needs one.
    assign take      = tok_reg.valid && !cmd.count_mode && free_reg && (tok_reg.val != '0);
    assign take_last = (tok_reg.val == iba_pkg::LEN_W'(1));

    // Token handed to the next cell: add this block to the count, or spend one block.
    always_comb
    begin
        tok_out.valid = tok_reg.valid;
        if (cmd.count_mode)
        begin
            tok_out.val = tok_reg.val
                        + {{(iba_pkg::LEN_W-1){1'b0}}, (free_reg && !self_sel)};
        end
        else
        begin
            tok_out.val = tok_reg.val - {{(iba_pkg::LEN_W-1){1'b0}}, take};
        end
    end

    // Next free bit and token.
    always_comb
    begin
        free_next = free_reg && !(cmd.clr && self_sel) && !(take && cmd.shift_en);
        tok_next  = tok_reg;
        if (cmd.flush)
        begin
            tok_next = '0;
        end
        else if (cmd.shift_en)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b1;
            tok_reg  <= '0;
        end
        else
        begin
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

endmodule

>>> hdl/iba_checker.sv
`timescale 1ns / 1ps
`include "indexed_block_allocator_unit_assert.svh"

module iba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [iba_pkg::STATUS_W-1:0]   status,
    input logic [iba_pkg::BLK_NUM_W-1:0]  block_number,
    input logic                           last
);

    logic single_code;

    // Status codes that never come with a block number or a following result.
    assign single_code = (status == iba_pkg::ST_MARKED) || (status == iba_pkg::ST_BAD_INDEX)
                         || (status == iba_pkg::ST_NO_SPACE);

    // A waiting result item is not withdrawn.
    `IBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Mark and error results carry no block number.
    `IBA_ASSERT_IMPL(a_no_blk, out_valid && single_code, block_number == '0)

    // Mark and error results are always the only result of their item.
    `IBA_ASSERT_IMPL(a_single, out_valid && single_code, last)

    // A new item is taken only while no result but a final one is waiting.
    `IBA_ASSERT_IMPL(a_busy, in_ready && out_valid, last)

endmodule

bind indexed_block_allocator_unit iba_checker u_iba_checker (.*);

>>> tb/tb_indexed_block_allocator_unit.sv
`timescale 1ns / 1ps

module tb_indexed_block_allocator_unit;

    import iba_pkg::*;

    localparam int NBLK        = NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS  = 350;

    // One result of the allocator as the checker sees it.
    typedef struct packed {
        status_t              code;
        logic [BLK_NUM_W-1:0] blk;
        logic                 fin;
    } grant_t;

    // Keeps a private copy of the free map and the queue of results still owed.
    class block_map_scoreboard;
        logic [NBLK-1:0] free_map;
        grant_t          expected_grants[$];
        int              fail_count;

        function new();
            free_map   = '1;
            fail_count = 0;
        endfunction

        function void queue_grant(status_t st, logic [BLK_NUM_W-1:0] blk, logic fin);
            grant_t g;
            g.code = st;
            g.blk  = blk;
            g.fin  = fin;
            expected_grants.push_back(g);
        endfunction

        // Works out the results of one accepted item and updates the map.
        function void predict_grants(logic opc, logic [BLK_IDX_W-1:0] idx,
                                     logic [LEN_W-1:0] len);
            int free_others;
            int taken;
            if (opc == OP_MARK) begin
                if (idx >= NBLK) begin
                    queue_grant(ST_BAD_INDEX, '0, 1'b1);
                end
                else begin
                    free_map[idx] = 1'b0;
                    queue_grant(ST_MARKED, '0, 1'b1);
                end
                return;
            end
            if (idx >= NBLK || !free_map[idx]) begin
                queue_grant(ST_BAD_INDEX, '0, 1'b1);
                return;
            end
            // The index block is taken first; the data blocks must come from the rest.
            free_map[idx] = 1'b0;
            free_others = $countones(free_map);
            if (len > MAX_DATA || free_others < len) begin
                free_map[idx] = 1'b1;
                queue_grant(ST_NO_SPACE, '0, 1'b1);
                return;
            end
            queue_grant(ST_INDEX, idx[BLK_NUM_W-1:0], len == 0);
            taken = 0;
            for (int b = 0; b < NBLK && taken < len; b++) begin
                if (free_map[b]) begin
                    free_map[b] = 1'b0;
                    taken++;
                    queue_grant(ST_DATA, BLK_NUM_W'(b), taken == len);
                end
            end
        endfunction

        function void report_failure(string what, grant_t want, logic [STATUS_W-1:0] st,
                                     logic [BLK_NUM_W-1:0] blk, logic fin);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: %s: expected status %0d block %0d last %0d, got %0d %0d %0d",
                         $realtime, what, want.code, want.blk, want.fin, st, blk, fin);
            end
        endfunction

        // Compares one accepted result with the oldest one still owed.
        function void check_grant(logic [STATUS_W-1:0] st, logic [BLK_NUM_W-1:0] blk,
                                  logic fin);
            grant_t want;
            if (expected_grants.size() == 0) begin
                want = '0;
                report_failure("unexpected result", want, st, blk, fin);
                return;
            end
            want = expected_grants.pop_front();
            if (st !== want.code || blk !== want.blk || fin !== want.fin) begin
                report_failure("result mismatch", want, st, blk, fin);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 op;
    logic [BLK_IDX_W-1:0] block_index;
    logic [LEN_W-1:0]     file_length;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [BLK_NUM_W-1:0] block_number;
    logic                 last;

    block_map_scoreboard sb = new();
    int                  cycle_count = 0;

    indexed_block_allocator_unit #(
        .NUM_BLOCKS(NBLK)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .block_index (block_index),
        .file_length (file_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .block_number(block_number),
        .last        (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_indexed_block_allocator_unit NOT OK");
            $finish;
        end
    end

    // Result monitor: values seen here are those from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_grant(status, block_number, last);
        end
    end

    // Receiver stalls: runs of ready, then short or occasionally long stalls.
    initial
    begin
        int run_len;
        int stall_len;
        int r;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            run_len = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            if (r < 25)      stall_len = 0;
            else if (r < 90) stall_len = $urandom_range(1, 3);
            else             stall_len = $urandom_range(8, 40);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (stall_len > 0) begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Sender gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one item, waits for its acceptance, then idles for the gap.
    task automatic send_item(input logic opc, input logic [BLK_IDX_W-1:0] idx,
                             input logic [LEN_W-1:0] len, input int gap);
        op          <= opc;
        block_index <= idx;
        file_length <= len;
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.predict_grants(opc, idx, len);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_grants.size() != 0) @(posedge clk);
    endtask

    // Main stimulus.
    initial
    begin
        logic                 opc;
        logic [BLK_IDX_W-1:0] idx;
        logic [LEN_W-1:0]     len;
        int                   r;
        int                   burst_left;
        int                   gap;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_MARK;
        block_index = '0;
        file_length = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero length, occupied and out-of-range index, oversized and
        // too-large requests, marks out of range and of used blocks, then real files.
        send_item(OP_ALLOC, 6'd5, 6'd0, pick_gap());
        send_item(OP_ALLOC, 6'd5, 6'd1, pick_gap());
        send_item(OP_ALLOC, 6'd40, 6'd2, pick_gap());
        send_item(OP_ALLOC, 6'd63, 6'd63, pick_gap());
        send_item(OP_ALLOC, 6'd0, 6'd33, pick_gap());
        send_item(OP_ALLOC, 6'd0, 6'd63, pick_gap());
        send_item(OP_ALLOC, 6'd0, 6'd31, pick_gap());
        send_item(OP_MARK, 6'd63, 6'd0, pick_gap());
        send_item(OP_MARK, 6'd32, 6'd0, pick_gap());
        send_item(OP_MARK, 6'd31, 6'd63, pick_gap());
        send_item(OP_MARK, 6'd31, 6'd0, pick_gap());
        send_item(OP_MARK, 6'd0, 6'd0, pick_gap());
        send_item(OP_ALLOC, 6'd1, 6'd3, pick_gap());
        send_item(OP_ALLOC, 6'd30, 6'd10, pick_gap());
        send_item(OP_ALLOC, 6'd16, 6'd14, pick_gap());
        send_item(OP_ALLOC, 6'd20, 6'd2, 0);
        send_item(OP_ALLOC, 6'd21, 6'd1, 0);
        drain_results();

        // Random part: mostly allocations with small lengths, some marks and
        // out-of-range or oversized values, with bursts that never idle.
        burst_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) drain_results();
            opc = ($urandom_range(0, 99) < 25) ? OP_MARK : OP_ALLOC;
            if ($urandom_range(0, 99) < 15) idx = BLK_IDX_W'($urandom_range(NBLK, 63));
            else                            idx = BLK_IDX_W'($urandom_range(0, NBLK - 1));
            r = $urandom_range(0, 99);
            if (r < 60)      len = LEN_W'($urandom_range(0, 3));
            else if (r < 85) len = LEN_W'($urandom_range(4, 12));
            else             len = LEN_W'($urandom_range(0, 63));
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end
            else begin
                gap = pick_gap();
                if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
            end
            send_item(opc, idx, len, gap);
        end

        // Let everything owed arrive, then watch for stray results.
        drain_results();
        repeat (2 * NBLK + 8) @(posedge clk);
        if (sb.fail_count == 0) begin
            $display("tb_indexed_block_allocator_unit OK");
        end
        else begin
            $display("tb_indexed_block_allocator_unit NOT OK");
        end
        $finish;
    end

endmodule
